// ----- rtl/pr4d_pkg.sv -----
// ----------------------------------------------------------------------------
// pr4d_pkg: shared types and constants of the 4D plane rotation
// Angle reduction limits, the CORDIC arctangent table, plane codes and the
// control record that travels with each item down the pipeline.
// ----------------------------------------------------------------------------
package pr4d_pkg;

  // Angle input: degrees with 16 fraction bits, signed.
  localparam int ANGLE_W = 26;
  // Reduction arithmetic carries one extra bit so that adding two full turns fits.
  localparam int RED_W = ANGLE_W + 1;

  localparam int DEG_FULL    = 23592960;
  localparam int DEG_HALF    = 11796480;
  localparam int DEG_QUARTER = 5898240;

  // pi/180 in Q46, split into a high and a low part for two narrow multipliers.
  localparam logic [40:0] RAD_PER_DEG_Q46 = 41'd1228166276391;
  localparam int K_SPLIT   = 20;
  localparam int KH_W      = 41 - K_SPLIT + 1;
  localparam int KL_W      = K_SPLIT + 1;
  localparam int Z_SUM_W   = 66;
  localparam int Z_SHIFT   = 32;

  // CORDIC datapath width: Q30 values with headroom for growth and residual angle.
  localparam int CS_W = 34;
  // Cosine and sine after clamping to [-1, 1] in Q30.
  localparam int COEF_W = 32;

  localparam int GAIN_INV_Q30 = 652032874;
  localparam int ONE_Q30      = 1073741824;

  // Coordinates are split at this bit for the output multiplications.
  localparam int LO_BITS = 16;

  // Plane codes.
  localparam logic [2:0] PLANE_XY = 3'd0;
  localparam logic [2:0] PLANE_YZ = 3'd1;
  localparam logic [2:0] PLANE_ZW = 3'd2;
  localparam logic [2:0] PLANE_XW = 3'd3;
  localparam logic [2:0] PLANE_XZ = 3'd4;
  localparam logic [2:0] PLANE_YW = 3'd5;

  // Coordinate slots inside the packed vector, x lowest.
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  // Control record carried along with each item.
  typedef struct packed {
    logic [2:0] func;
    logic       neg;
  } pr4d_ctrl_t;

  // atan(2^-i) in Q30 radians.
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0:  v = 31'd843314857;
      1:  v = 31'd497837829;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048576;
      11: v = 31'd524288;
      12: v = 31'd262144;
      13: v = 31'd131072;
      14: v = 31'd65536;
      15: v = 31'd32768;
      16: v = 31'd16384;
      17: v = 31'd8192;
      18: v = 31'd4096;
      19: v = 31'd2048;
      20: v = 31'd1024;
      21: v = 31'd512;
      22: v = 31'd256;
      23: v = 31'd128;
      24: v = 31'd64;
      25: v = 31'd32;
      26: v = 31'd16;
      27: v = 31'd8;
      28: v = 31'd4;
      29: v = 31'd2;
      30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pr4d_reduce.sv -----
// ----------------------------------------------------------------------------
// pr4d_reduce: angle reduction and conversion to radians
// Reduces the angle into one turn, folds it into [-90, 90] degrees and
// converts it to a Q30 radian angle for the CORDIC chain, in five slots.
// ----------------------------------------------------------------------------
module pr4d_reduce #(
  parameter int CW = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic [2:0]                         up_func,
  input  logic signed [pr4d_pkg::ANGLE_W-1:0] up_angle,
  input  logic [4*CW-1:0]                    up_crd,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output pr4d_pkg::pr4d_ctrl_t               dn_ctrl,
  output logic signed [pr4d_pkg::CS_W-1:0]   dn_z,
  output logic [4*CW-1:0]                    dn_crd
);
  import pr4d_pkg::*;

  localparam int NS   = 5;
  localparam int PH_W = RED_W + KH_W;
  localparam int PL_W = RED_W + KL_W;

  localparam logic signed [RED_W-1:0] FULL    = RED_W'(DEG_FULL);
  localparam logic signed [RED_W-1:0] FULL2   = RED_W'(2 * DEG_FULL);
  localparam logic signed [RED_W-1:0] HALF    = RED_W'(DEG_HALF);
  localparam logic signed [RED_W-1:0] QUARTER = RED_W'(DEG_QUARTER);
  localparam logic signed [KH_W-1:0]  K_HI    =
    $signed({1'b0, RAD_PER_DEG_Q46[40:K_SPLIT]});
  localparam logic signed [KL_W-1:0]  K_LO    =
    $signed({1'b0, RAD_PER_DEG_Q46[K_SPLIT-1:0]});
  localparam logic signed [Z_SUM_W-1:0] Z_ROUND =
    {{(Z_SUM_W-Z_SHIFT){1'b0}}, 1'b1, {(Z_SHIFT-1){1'b0}}};

  logic [NS-1:0] vld_r;
  logic [NS:0]   take;

  pr4d_ctrl_t ctrl_r [NS];
  pr4d_ctrl_t ctrl_nxt [NS];
  logic [4*CW-1:0] crd_r [NS];

  logic signed [RED_W-1:0]  r1_r, r1_nxt;
  logic signed [RED_W-1:0]  t2_r, t2_nxt;
  logic signed [RED_W-1:0]  r3_r, r3_nxt;
  logic signed [PH_W-1:0]   ph_r, ph_nxt;
  logic signed [PL_W-1:0]   pl_r, pl_nxt;
  logic signed [CS_W-1:0]   z_r, z_nxt;

  // A slot takes a new item when it is empty or its item moves on.
  always_comb begin
    take[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      take[k] = !vld_r[k] || take[k+1];
    end
  end

  assign up_ready = take[0];

  // Slot datapath.
  always_comb begin
    logic signed [RED_W-1:0]   a;
    logic signed [Z_SUM_W-1:0] zsum;
    a = {up_angle[ANGLE_W-1], up_angle};

    // One full turn into [0, 360) degrees.
    if (a < -FULL) begin
      r1_nxt = a + FULL2;
    end else if (a < 0) begin
      r1_nxt = a + FULL;
    end else if (a >= FULL) begin
      r1_nxt = a - FULL;
    end else begin
      r1_nxt = a;
    end

    // Into (-180, 180] degrees.
    t2_nxt = (r1_r > HALF) ? r1_r - FULL : r1_r;

    // Into [-90, 90] degrees; a half-turn fold flips both cosine and sine.
    ctrl_nxt[0].func = up_func;
    ctrl_nxt[0].neg  = 1'b0;
    ctrl_nxt[1]      = ctrl_r[0];
    ctrl_nxt[2]      = ctrl_r[1];
    if (t2_r > QUARTER) begin
      r3_nxt           = t2_r - HALF;
      ctrl_nxt[2].neg  = 1'b1;
    end else if (t2_r < -QUARTER) begin
      r3_nxt           = t2_r + HALF;
      ctrl_nxt[2].neg  = 1'b1;
    end else begin
      r3_nxt           = t2_r;
    end
    ctrl_nxt[3] = ctrl_r[2];
    ctrl_nxt[4] = ctrl_r[3];

    // Degrees times pi/180 as two partial products.
    ph_nxt = r3_r * K_HI;
    pl_nxt = r3_r * K_LO;

    // Recombine, round and drop to Q30 radians.
    zsum  = (Z_SUM_W'(ph_r) <<< K_SPLIT) + Z_SUM_W'(pl_r) + Z_ROUND;
    z_nxt = zsum[Z_SHIFT +: CS_W];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (take[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (take[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take[0]) begin
      ctrl_r[0] <= ctrl_nxt[0];
      crd_r[0]  <= up_crd;
    end
    for (int k = 1; k < NS; k++) begin
      if (take[k]) begin
        ctrl_r[k] <= ctrl_nxt[k];
        crd_r[k]  <= crd_r[k-1];
      end
    end
    if (take[0]) r1_r <= r1_nxt;
    if (take[1]) t2_r <= t2_nxt;
    if (take[2]) r3_r <= r3_nxt;
    if (take[3]) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (take[4]) z_r <= z_nxt;
  end

  assign dn_valid = vld_r[NS-1];
  assign dn_ctrl  = ctrl_r[NS-1];
  assign dn_z     = z_r;
  assign dn_crd   = crd_r[NS-1];

endmodule

// ----- rtl/pr4d_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pr4d_cordic_cell: one rotation-mode CORDIC iteration
// Holds one item of the chain and performs the shift-add step of its index,
// then hands the item to the next cell.
// ----------------------------------------------------------------------------
module pr4d_cordic_cell #(
  parameter int CW    = 32,
  parameter int STAGE = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  pr4d_pkg::pr4d_ctrl_t             up_ctrl,
  input  logic signed [pr4d_pkg::CS_W-1:0] up_x,
  input  logic signed [pr4d_pkg::CS_W-1:0] up_y,
  input  logic signed [pr4d_pkg::CS_W-1:0] up_z,
  input  logic [4*CW-1:0]                  up_crd,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output pr4d_pkg::pr4d_ctrl_t             dn_ctrl,
  output logic signed [pr4d_pkg::CS_W-1:0] dn_x,
  output logic signed [pr4d_pkg::CS_W-1:0] dn_y,
  output logic signed [pr4d_pkg::CS_W-1:0] dn_z,
  output logic [4*CW-1:0]                  dn_crd
);
  import pr4d_pkg::*;

  localparam logic signed [CS_W-1:0] ATAN = CS_W'(atan_q30(STAGE));

  logic                   vld_r;
  logic                   take;
  pr4d_ctrl_t             ctrl_r;
  logic [4*CW-1:0]        crd_r;
  logic signed [CS_W-1:0] x_r, x_nxt;
  logic signed [CS_W-1:0] y_r, y_nxt;
  logic signed [CS_W-1:0] z_r, z_nxt;

  assign take     = !vld_r || dn_ready;
  assign up_ready = take;

  // Rotate toward a zero residual angle; a residual of zero rotates forward.
  always_comb begin
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;
    dx = up_y >>> STAGE;
    dy = up_x >>> STAGE;
    if (!up_z[CS_W-1]) begin
      x_nxt = up_x - dx;
      y_nxt = up_y + dy;
      z_nxt = up_z - ATAN;
    end else begin
      x_nxt = up_x + dx;
      y_nxt = up_y - dy;
      z_nxt = up_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctrl_r <= up_ctrl;
      crd_r  <= up_crd;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_ctrl  = ctrl_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_z     = z_r;
  assign dn_crd   = crd_r;

endmodule

// ----- rtl/pr4d_rotate.sv -----
// ----------------------------------------------------------------------------
// pr4d_rotate: Givens rotation of the selected coordinate pair
// Clamps cosine and sine, picks the plane, forms the exact rounded products
// and saturates the rotated pair into the output register, in five slots.
// ----------------------------------------------------------------------------
module pr4d_rotate #(
  parameter int CW = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  pr4d_pkg::pr4d_ctrl_t             up_ctrl,
  input  logic signed [pr4d_pkg::CS_W-1:0] up_x,
  input  logic signed [pr4d_pkg::CS_W-1:0] up_y,
  input  logic [4*CW-1:0]                  up_crd,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic [4*CW-1:0]                  dn_crd,
  output logic                             dn_bad
);
  import pr4d_pkg::*;

  localparam int NS     = 5;
  localparam int UH_W   = CW - LO_BITS + 1;
  localparam int PH_W   = COEF_W + UH_W;
  localparam int PL_W   = COEF_W + LO_BITS + 1;
  localparam int ACC_W  = CW + 35;
  localparam int ACCS_W = ACC_W - 30;

  localparam logic signed [CS_W-1:0]   ONE     = CS_W'(ONE_Q30);
  localparam logic signed [CS_W-1:0]   NEG_ONE = -ONE;
  localparam logic signed [ACC_W-1:0]  ROUND   =
    {{(ACC_W-30){1'b0}}, 1'b1, 29'd0};
  localparam logic signed [ACCS_W-1:0] SAT_HI  =
    {{(ACCS_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [ACCS_W-1:0] SAT_LO  = ~SAT_HI;

  logic [NS-1:0] vld_r;
  logic [NS:0]   take;

  // Slot 1: clamped cosine and sine.
  pr4d_ctrl_t               ctrl1_r;
  logic [4*CW-1:0]          crd1_r;
  logic signed [COEF_W-1:0] c1_r, c1_nxt;
  logic signed [COEF_W-1:0] s1_r, s1_nxt;

  // Slot 2: selected pair and coefficients.
  logic [4*CW-1:0]          crd2_r;
  logic signed [CW-1:0]     u2_r, u2_nxt;
  logic signed [CW-1:0]     v2_r, v2_nxt;
  logic signed [COEF_W-1:0] pa2_r, pa2_nxt, pb2_r, pb2_nxt;
  logic signed [COEF_W-1:0] qa2_r, qa2_nxt, qb2_r, qb2_nxt;
  logic [1:0]               ia2_r, ia2_nxt, ib2_r, ib2_nxt;
  logic                     bad2_r, bad2_nxt;

  // Slot 3: partial products.
  logic [4*CW-1:0]          crd3_r;
  logic signed [PH_W-1:0]   pah3_r, pah3_nxt, pbh3_r, pbh3_nxt;
  logic signed [PH_W-1:0]   qah3_r, qah3_nxt, qbh3_r, qbh3_nxt;
  logic signed [PL_W-1:0]   pal3_r, pal3_nxt, pbl3_r, pbl3_nxt;
  logic signed [PL_W-1:0]   qal3_r, qal3_nxt, qbl3_r, qbl3_nxt;
  logic [1:0]               ia3_r, ib3_r;
  logic                     bad3_r;

  // Slot 4: rounded sums.
  logic [4*CW-1:0]          crd4_r;
  logic signed [ACCS_W-1:0] p4_r, p4_nxt, q4_r, q4_nxt;
  logic [1:0]               ia4_r, ib4_r;
  logic                     bad4_r;

  // Slot 5: output register.
  logic [4*CW-1:0]          crd5_r, crd5_nxt;
  logic                     bad5_r;

  always_comb begin
    take[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      take[k] = !vld_r[k] || take[k+1];
    end
  end

  assign up_ready = take[0];

  // Clamp to [-1, 1] and apply the half-turn sign.
  always_comb begin
    logic signed [CS_W-1:0] cx;
    logic signed [CS_W-1:0] sy;
    if (up_x > ONE) begin
      cx = ONE;
    end else if (up_x < NEG_ONE) begin
      cx = NEG_ONE;
    end else begin
      cx = up_x;
    end
    if (up_y > ONE) begin
      sy = ONE;
    end else if (up_y < NEG_ONE) begin
      sy = NEG_ONE;
    end else begin
      sy = up_y;
    end
    if (up_ctrl.neg) begin
      cx = -cx;
      sy = -sy;
    end
    c1_nxt = cx[COEF_W-1:0];
    s1_nxt = sy[COEF_W-1:0];
  end

  // Plane selection and sign convention.
  always_comb begin
    logic signed [COEF_W-1:0] ns;
    ns       = -s1_r;
    bad2_nxt = 1'b0;
    case (ctrl1_r.func)
      PLANE_XY: begin ia2_nxt = IDX_X; ib2_nxt = IDX_Y; end
      PLANE_YZ: begin ia2_nxt = IDX_Y; ib2_nxt = IDX_Z; end
      PLANE_ZW: begin ia2_nxt = IDX_Z; ib2_nxt = IDX_W; end
      PLANE_XW: begin ia2_nxt = IDX_X; ib2_nxt = IDX_W; end
      PLANE_XZ: begin ia2_nxt = IDX_X; ib2_nxt = IDX_Z; end
      PLANE_YW: begin ia2_nxt = IDX_Y; ib2_nxt = IDX_W; end
      default: begin
        ia2_nxt  = IDX_X;
        ib2_nxt  = IDX_X;
        bad2_nxt = 1'b1;
      end
    endcase
    u2_nxt = crd1_r[ia2_nxt*CW +: CW];
    v2_nxt = crd1_r[ib2_nxt*CW +: CW];
    // XZ and YW turn the other way.
    if (ctrl1_r.func == PLANE_XZ || ctrl1_r.func == PLANE_YW) begin
      pa2_nxt = c1_r;
      pb2_nxt = ns;
      qa2_nxt = s1_r;
      qb2_nxt = c1_r;
    end else begin
      pa2_nxt = c1_r;
      pb2_nxt = s1_r;
      qa2_nxt = ns;
      qb2_nxt = c1_r;
    end
  end

  // Each coordinate is split into a signed high part and an unsigned low part.
  always_comb begin
    logic signed [UH_W-1:0]    uh;
    logic signed [UH_W-1:0]    vh;
    logic signed [LO_BITS:0]   ul;
    logic signed [LO_BITS:0]   vl;
    uh = UH_W'(u2_r >>> LO_BITS);
    vh = UH_W'(v2_r >>> LO_BITS);
    ul = $signed({1'b0, u2_r[LO_BITS-1:0]});
    vl = $signed({1'b0, v2_r[LO_BITS-1:0]});
    pah3_nxt = pa2_r * uh;
    pbh3_nxt = pb2_r * vh;
    qah3_nxt = qa2_r * uh;
    qbh3_nxt = qb2_r * vh;
    pal3_nxt = pa2_r * ul;
    pbl3_nxt = pb2_r * vl;
    qal3_nxt = qa2_r * ul;
    qbl3_nxt = qb2_r * vl;
  end

  // Exact sum, round to nearest and drop the Q30 scale.
  always_comb begin
    logic signed [ACC_W-1:0] pacc;
    logic signed [ACC_W-1:0] qacc;
    pacc = ((ACC_W'(pah3_r) + ACC_W'(pbh3_r)) <<< LO_BITS)
           + ACC_W'(pal3_r) + ACC_W'(pbl3_r) + ROUND;
    qacc = ((ACC_W'(qah3_r) + ACC_W'(qbh3_r)) <<< LO_BITS)
           + ACC_W'(qal3_r) + ACC_W'(qbl3_r) + ROUND;
    p4_nxt = pacc[ACC_W-1:30];
    q4_nxt = qacc[ACC_W-1:30];
  end

  // Saturate and put the rotated pair back in place.
  always_comb begin
    logic [CW-1:0] ps;
    logic [CW-1:0] qs;
    if (p4_r > SAT_HI) begin
      ps = SAT_HI[CW-1:0];
    end else if (p4_r < SAT_LO) begin
      ps = SAT_LO[CW-1:0];
    end else begin
      ps = p4_r[CW-1:0];
    end
    if (q4_r > SAT_HI) begin
      qs = SAT_HI[CW-1:0];
    end else if (q4_r < SAT_LO) begin
      qs = SAT_LO[CW-1:0];
    end else begin
      qs = q4_r[CW-1:0];
    end
    crd5_nxt = crd4_r;
    if (!bad4_r) begin
      crd5_nxt[ia4_r*CW +: CW] = ps;
      crd5_nxt[ib4_r*CW +: CW] = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (take[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (take[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      ctrl1_r <= up_ctrl;
      crd1_r  <= up_crd;
      c1_r    <= c1_nxt;
      s1_r    <= s1_nxt;
    end
    if (take[1]) begin
      crd2_r <= crd1_r;
      u2_r   <= u2_nxt;
      v2_r   <= v2_nxt;
      pa2_r  <= pa2_nxt;
      pb2_r  <= pb2_nxt;
      qa2_r  <= qa2_nxt;
      qb2_r  <= qb2_nxt;
      ia2_r  <= ia2_nxt;
      ib2_r  <= ib2_nxt;
      bad2_r <= bad2_nxt;
    end
    if (take[2]) begin
      crd3_r <= crd2_r;
      pah3_r <= pah3_nxt;
      pbh3_r <= pbh3_nxt;
      qah3_r <= qah3_nxt;
      qbh3_r <= qbh3_nxt;
      pal3_r <= pal3_nxt;
      pbl3_r <= pbl3_nxt;
      qal3_r <= qal3_nxt;
      qbl3_r <= qbl3_nxt;
      ia3_r  <= ia2_r;
      ib3_r  <= ib2_r;
      bad3_r <= bad2_r;
    end
    if (take[3]) begin
      crd4_r <= crd3_r;
      p4_r   <= p4_nxt;
      q4_r   <= q4_nxt;
      ia4_r  <= ia3_r;
      ib4_r  <= ib3_r;
      bad4_r <= bad3_r;
    end
    if (take[4]) begin
      crd5_r <= crd5_nxt;
      bad5_r <= bad4_r;
    end
  end

  assign dn_valid = vld_r[NS-1];
  assign dn_crd   = crd5_r;
  assign dn_bad   = bad5_r;

endmodule

// ----- rtl/plane_rotation_4d_top.sv -----
// ----------------------------------------------------------------------------
// plane_rotation_4d_top: CORDIC plane rotation of a 4D vector
// Rotates the coordinate pair of one plane by an angle in degrees; the other
// coordinates pass through. Sine and cosine come from a chain of CORDIC cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low to high)                 | tuser
//  --------+-----------+-------------------------------------+-----------
//  in_     | slave     | angle, coord_x, coord_y, coord_z,   | func
//          |           | coord_w, zero fill to whole bytes   |
//  out_    | master    | out_x, out_y, out_z, out_w,         | bad_plane
//          |           | zero fill to whole bytes            |
//
// One item is accepted per cycle while the slots are not backed up; an item
// passes through five reduction slots, one CORDIC cell per iteration and
// five rotation slots. Reset clears only the valid bits of the slots. Every
// slot holds its item while the slot after it is full and cannot move on, so
// empty slots keep filling while a result waits in the output register.
//
module plane_rotation_4d_top #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 18
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // angle, coord_x, coord_y, coord_z, coord_w, zero fill
  input  logic [((pr4d_pkg::ANGLE_W+4*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // func
  input  logic [2:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // out_x, out_y, out_z, out_w, zero fill
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // bad_plane
  output logic [0:0] out_tuser
);
  import pr4d_pkg::*;

  localparam int CW         = COORD_WIDTH;
  localparam int OUT_DATA_W = ((4 * CW + 7) / 8) * 8;

  logic                   stg_vld  [CORDIC_STAGES+1];
  logic                   stg_rdy  [CORDIC_STAGES+1];
  pr4d_ctrl_t             stg_ctrl [CORDIC_STAGES+1];
  logic signed [CS_W-1:0] stg_x    [CORDIC_STAGES+1];
  logic signed [CS_W-1:0] stg_y    [CORDIC_STAGES+1];
  logic signed [CS_W-1:0] stg_z    [CORDIC_STAGES+1];
  logic [4*CW-1:0]        stg_crd  [CORDIC_STAGES+1];
  logic [4*CW-1:0]        res_crd;
  logic                   res_bad;

  // Angle reduction and radian conversion.
  pr4d_reduce #(
    .CW(CW)
  ) u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_func  (in_tuser),
    .up_angle ($signed(in_tdata[ANGLE_W-1:0])),
    .up_crd   (in_tdata[ANGLE_W +: 4*CW]),
    .dn_valid (stg_vld[0]),
    .dn_ready (stg_rdy[0]),
    .dn_ctrl  (stg_ctrl[0]),
    .dn_z     (stg_z[0]),
    .dn_crd   (stg_crd[0])
  );

  // The chain starts from the inverse CORDIC gain on the x axis.
  assign stg_x[0] = CS_W'(GAIN_INV_Q30);
  assign stg_y[0] = '0;

  // One cell per CORDIC iteration.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_chain
    pr4d_cordic_cell #(
      .CW    (CW),
      .STAGE (i)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_vld[i]),
      .up_ready (stg_rdy[i]),
      .up_ctrl  (stg_ctrl[i]),
      .up_x     (stg_x[i]),
      .up_y     (stg_y[i]),
      .up_z     (stg_z[i]),
      .up_crd   (stg_crd[i]),
      .dn_valid (stg_vld[i+1]),
      .dn_ready (stg_rdy[i+1]),
      .dn_ctrl  (stg_ctrl[i+1]),
      .dn_x     (stg_x[i+1]),
      .dn_y     (stg_y[i+1]),
      .dn_z     (stg_z[i+1]),
      .dn_crd   (stg_crd[i+1])
    );
  end

  // Rotation of the selected pair and output register.
  pr4d_rotate #(
    .CW(CW)
  ) u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_vld[CORDIC_STAGES]),
    .up_ready (stg_rdy[CORDIC_STAGES]),
    .up_ctrl  (stg_ctrl[CORDIC_STAGES]),
    .up_x     (stg_x[CORDIC_STAGES]),
    .up_y     (stg_y[CORDIC_STAGES]),
    .up_crd   (stg_crd[CORDIC_STAGES]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_crd   (res_crd),
    .dn_bad   (res_bad)
  );

  assign out_tdata = OUT_DATA_W'(res_crd);
  assign out_tuser = res_bad;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for plane_rotation_4d_top
// Drives 4D vectors with plane codes and angles into the stream input and
// checks every rotated vector against a bit-exact CORDIC and Givens-rotation
// predictor. A short directed table comes first, then random vectors.
// Both sides idle in random bursts. One long output hold-off backs up the
// pipeline until the input stalls.
// ----------------------------------------------------------------------------
module tb;
  import pr4d_pkg::*;

  localparam int CW             = 32;
  localparam int STAGES         = 18;
  localparam int LATENCY        = 10 + STAGES;
  localparam int IN_W           = ((ANGLE_W + 4 * CW + 7) / 8) * 8;
  localparam int OUT_W          = ((4 * CW + 7) / 8) * 8;
  localparam int N_ITEMS        = 1450;
  localparam int CALM_TAIL      = 150;
  localparam int HOLD_AT        = 500;
  localparam int HOLD_CYCLES    = 240;
  localparam int WATCHDOG_LIMIT = 1000;

  // Plane codes that the block rejects.
  localparam logic [2:0] PLANE_RSV6 = 3'd6;
  localparam logic [2:0] PLANE_RSV7 = 3'd7;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint UNIT_Q30  = longint'(1) <<< 30;
  localparam longint RAD_Q46   = 64'sd1228166276391;
  localparam longint CORDIC_X0 = 64'sd652032874;

  // atan(2^-i) in Q30 radians.
  localparam longint ATAN_Q30 [0:31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [2:0]                 plane;
    logic signed [ANGLE_W-1:0]  angle;
    logic signed [CW-1:0]       x;
    logic signed [CW-1:0]       y;
    logic signed [CW-1:0]       z;
    logic signed [CW-1:0]       w;
  } rot_req_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] w;
    logic                 bad;
  } rot_res_t;

  typedef struct packed {
    rot_req_t req;
    logic     typed;
    rot_res_t exp;
  } stim_row_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic [2:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0]       out_tuser;

  rot_res_t rotations_due[$];
  int       errors        = 0;
  int       items_sent    = 0;
  int       bad_sent      = 0;
  int       quiet_cycles  = 0;
  int       stall_run     = 0;
  int       longest_stall = 0;
  bit       calm          = 1'b0;
  bit       hold_req      = 1'b0;
  bit       holding       = 1'b0;

  plane_rotation_4d_top #(
    .COORD_WIDTH   (CW),
    .CORDIC_STAGES (STAGES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock with a 20-unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  function automatic longint unit_clamp(longint v);
    if (v > UNIT_Q30) return UNIT_Q30;
    if (v < -UNIT_Q30) return -UNIT_Q30;
    return v;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(longint v);
    if (v > COORD_MAX) return C_MAX;
    if (v < COORD_MIN) return C_MIN;
    return v[CW-1:0];
  endfunction

  // Cosine and sine in Q30 of an angle in 1/65536 degree.
  function automatic void cordic_sincos(input logic signed [ANGLE_W-1:0] ang,
                                        output longint cos_q, output longint sin_q);
    longint r;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    flip = 1'b0;
    // Reduce into [0, 360), then fold into [-90, 90].
    r = longint'(ang) % DEG_FULL;
    if (r < 0) r = r + DEG_FULL;
    if (r > DEG_HALF) r = r - DEG_FULL;
    if (r > DEG_QUARTER) begin
      r = r - DEG_HALF;
      flip = 1'b1;
    end else if (r < -DEG_QUARTER) begin
      r = r + DEG_HALF;
      flip = 1'b1;
    end
    z = (r * RAD_Q46 + (longint'(1) <<< 31)) >>> 32;
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q30[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q30[i];
      end
    end
    x = unit_clamp(x);
    y = unit_clamp(y);
    cos_q = flip ? -x : x;
    sin_q = flip ? -y : y;
  endfunction

  // Rounded (c1*u + c2*v) / 2^30, saturated to the coordinate range.
  function automatic longint rot_mix(longint c1, longint u, longint c2, longint v);
    return longint'(sat_coord((c1 * u + c2 * v + (longint'(1) <<< 29)) >>> 30));
  endfunction

  function automatic rot_res_t rotate_vector(rot_req_t q);
    longint   crd [4];
    longint   c;
    longint   s;
    longint   p;
    longint   t;
    int       a;
    int       b;
    rot_res_t res;
    crd[IDX_X] = q.x;
    crd[IDX_Y] = q.y;
    crd[IDX_Z] = q.z;
    crd[IDX_W] = q.w;
    a = 0;
    b = 0;
    res.bad = 1'b0;
    case (q.plane)
      PLANE_XY: begin a = IDX_X; b = IDX_Y; end
      PLANE_YZ: begin a = IDX_Y; b = IDX_Z; end
      PLANE_ZW: begin a = IDX_Z; b = IDX_W; end
      PLANE_XW: begin a = IDX_X; b = IDX_W; end
      PLANE_XZ: begin a = IDX_X; b = IDX_Z; end
      PLANE_YW: begin a = IDX_Y; b = IDX_W; end
      default:  res.bad = 1'b1;
    endcase
    if (!res.bad) begin
      cordic_sincos(q.angle, c, s);
      // XZ and YW turn the other way round.
      if (q.plane == PLANE_XZ || q.plane == PLANE_YW) begin
        p = rot_mix(c, crd[a], -s, crd[b]);
        t = rot_mix(s, crd[a], c, crd[b]);
      end else begin
        p = rot_mix(c, crd[a], s, crd[b]);
        t = rot_mix(-s, crd[a], c, crd[b]);
      end
      crd[a] = p;
      crd[b] = t;
    end
    res.x = sat_coord(crd[IDX_X]);
    res.y = sat_coord(crd[IDX_Y]);
    res.z = sat_coord(crd[IDX_Z]);
    res.w = sat_coord(crd[IDX_W]);
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic rot_req_t dir_row(logic [2:0] plane, int angle,
                                       logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                       logic signed [CW-1:0] z, logic signed [CW-1:0] w);
    rot_req_t q;
    q.plane = plane;
    q.angle = ANGLE_W'(angle);
    q.x = x;
    q.y = y;
    q.z = z;
    q.w = w;
    return q;
  endfunction

  // Mix of full-range, small, mid-size and near-limit coordinates.
  function automatic logic signed [CW-1:0] rand_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = CW'($urandom);
      2:    v = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      3:    v = CW'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      4: begin
        case ($urandom_range(0, 4))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = '0;
          3: v = '1;
          default: v = CW'(1);
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) != 0) v = C_MAX - CW'($urandom_range(0, 65535));
        else v = C_MIN + CW'($urandom_range(0, 65535));
      end
    endcase
    return v;
  endfunction

  // Uniform angles, angles near multiples of 90 degrees and tiny angles.
  function automatic int rand_angle();
    int a;
    case ($urandom_range(0, 3))
      0, 1: a = int'($urandom_range(0, 2 * DEG_FULL)) - DEG_FULL;
      2: begin
        a = (int'($urandom_range(0, 8)) - 4) * DEG_QUARTER + int'($urandom_range(0, 4)) - 2;
        if (a > DEG_FULL) a = DEG_FULL;
        if (a < -DEG_FULL) a = -DEG_FULL;
      end
      default: a = int'($urandom_range(0, 1 << 17)) - (1 << 16);
    endcase
    return a;
  endfunction

  function automatic rot_req_t rand_request();
    logic [2:0] plane;
    if ($urandom_range(0, 9) == 0) plane = 3'($urandom_range(PLANE_RSV6, PLANE_RSV7));
    else plane = 3'($urandom_range(PLANE_XY, PLANE_YW));
    return dir_row(plane, rand_angle(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord());
  endfunction

  // Offer one item and hold it until accepted; then log its expected result.
  task automatic send_item(rot_req_t req, rot_res_t want);
    logic [IN_W-1:0] word;
    word = '0;
    word[0 +: ANGLE_W]           = req.angle;
    word[ANGLE_W +: CW]          = req.x;
    word[ANGLE_W + CW +: CW]     = req.y;
    word[ANGLE_W + 2 * CW +: CW] = req.z;
    word[ANGLE_W + 3 * CW +: CW] = req.w;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= req.plane;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rotations_due.push_back(want);
    items_sent++;
    if (want.bad) bad_sent++;
  endtask

  // Random idle burst on the input side, skipped under pressure and in the tail.
  task automatic maybe_gap();
    if (!calm && !hold_req && !holding && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------

  initial begin
    stim_row_t rows[$];
    rot_req_t  req;
    int        n_dir;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: limits of the angle, fold boundaries, every plane,
    // saturation in both directions and the rejected plane codes.
    rows.push_back('{dir_row(PLANE_XY, 0, CW'(32'sh10000), CW'(32'sh20000), 3, 4), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_YZ, DEG_QUARTER, C_MAX, C_MIN, C_MAX, 1), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_ZW, -DEG_QUARTER, 5, 6, C_MIN, C_MAX), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XW, DEG_HALF, C_MAX, 7, 8, C_MIN), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XZ, -DEG_HALF, 12345, -1, -98765, 2), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_YW, DEG_FULL, 1, 65536, -2, -65536), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XY, -DEG_FULL, -65536, 65536, 0, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_YZ, DEG_QUARTER / 2, C_MAX, C_MAX, C_MAX, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XY, DEG_QUARTER / 2, C_MAX, C_MAX, 0, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XY, -8847360, C_MIN, C_MIN, 0, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XZ, 17694720, 300000, -1, 400000, 9), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_YW, -17694720, 0, C_MAX, 0, C_MIN), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_ZW, 1, 0, 0, C_MAX, C_MAX), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XW, -1, C_MIN, 0, 0, C_MIN), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XZ, 1966080, 65536, 0, 131072, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_YW, 13107200, 0, -655360, 0, 327680), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XY, DEG_QUARTER + 1, 1000000, 2000000, 0, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XY, -DEG_QUARTER - 1, 1000000, -2000000, 0, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_XW, DEG_HALF + 1, 777, 0, 0, -777), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_YZ, 8060928, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{dir_row(PLANE_ZW, DEG_HALF, 0, 0, C_MIN, C_MIN), 1'b0, '0});
    // Rejected plane codes return the vector untouched with the flag set.
    rows.push_back('{dir_row(PLANE_RSV6, DEG_QUARTER, C_MAX, C_MIN, 0, -1), 1'b1,
                     {C_MAX, C_MIN, CW'(0), CW'(-1), 1'b1}});
    rows.push_back('{dir_row(PLANE_RSV7, -DEG_FULL, 1, -2, C_MAX, C_MIN), 1'b1,
                     {CW'(1), CW'(-2), C_MAX, C_MIN, 1'b1}});
    n_dir = rows.size();

    foreach (rows[i]) begin
      send_item(rows[i].req, rows[i].typed ? rows[i].exp : rotate_vector(rows[i].req));
      maybe_gap();
    end

    // Random vectors; one long output hold-off, no idling in the tail.
    for (int i = n_dir; i < N_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i >= N_ITEMS - CALM_TAIL) calm = 1'b1;
      req = rand_request();
      send_item(req, rotate_vector(req));
      maybe_gap();
    end
    in_tvalid <= 1'b0;

    while (rotations_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Rotated %0d vectors across all six planes, %0d with a rejected plane code,",
             items_sent, bad_sent);
    $display("angles up to +-360 degrees; the input stalled for up to %0d cycles.",
             longest_stall);
    if (errors == 0 && rotations_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Output side: random stalls, one long hold-off, always ready in the tail
  // ------------------------------------------------------------------

  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !calm) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------

  task automatic check_coord(string tag, logic signed [CW-1:0] want_v,
                             logic signed [CW-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, tag, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : check_results
    rot_res_t got;
    rot_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x   = out_tdata[0 +: CW];
      got.y   = out_tdata[CW +: CW];
      got.z   = out_tdata[2 * CW +: CW];
      got.w   = out_tdata[3 * CW +: CW];
      got.bad = out_tuser[0];
      if (rotations_due.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, expected none, got %h", $time, got);
      end else begin
        want = rotations_due.pop_front();
        check_coord("out_x", want.x, got.x);
        check_coord("out_y", want.y, got.y);
        check_coord("out_z", want.z, got.z);
        check_coord("out_w", want.w, got.w);
        if (got.bad !== want.bad) begin
          errors++;
          $display("%0t: bad_plane expected %b, got %b", $time, want.bad, got.bad);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake; also tracks input stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_tvalid && !in_tready) begin
        stall_run <= stall_run + 1;
        if (stall_run + 1 > longest_stall) longest_stall <= stall_run + 1;
      end else begin
        stall_run <= 0;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
